### hdl/srtl_pkg.sv
// Shared types and codes for the sorted range table lookup block.
package srtl_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    localparam int ADDR_W  = 64;
    localparam int NAME_W  = 16;
    localparam int IDX_W   = 10;
    localparam int COUNT_W = 11;

    // one table row as stored in memory
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic [NAME_W-1:0] name;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### hdl/srtl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module srtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/sorted_range_table_lookup.sv
// Top level of the sorted range table lookup block.
//
// Usage: one command per input transfer on in_valid/in_ready; one result per
// command on out_valid/out_ready. Commands are clear, append, lookup and nop.
// Clear goes straight to its result. Append runs a binary search (a read and
// a compare state per probe, about log2(entries)+1 probes), then shifts each
// entry above the insert point up by one row, a read and a write per entry,
// then writes the new row. Lookup runs the same search, then walks backward,
// a read and a compare per visited entry. The table RAM has one registered
// read port, one read per probe or step.
// One item is in flight at a time: in_ready is high only while the block is
// idle and no result is waiting. A result is held in output registers until
// taken; the receiver may stall indefinitely and the block waits.
// Reset empties the table (count to zero) and drops any pending result;
// table contents are not cleared, since rows past the count are never read.
module sorted_range_table_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [srtl_pkg::ADDR_W-1:0]   entry_start,
    input  logic [srtl_pkg::ADDR_W-1:0]   entry_size,
    input  logic [srtl_pkg::NAME_W-1:0]   name_handle,
    input  logic [srtl_pkg::ADDR_W-1:0]   target_address,
    input  logic [srtl_pkg::ADDR_W-1:0]   original_address,
    input  logic [srtl_pkg::NAME_W-1:0]   module_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [srtl_pkg::IDX_W-1:0]    entry_index,
    output logic [srtl_pkg::NAME_W-1:0]   name_handle_out,
    output logic [srtl_pkg::ADDR_W-1:0]   offset,
    output logic [srtl_pkg::ADDR_W-1:0]   original_address_out,
    output logic [srtl_pkg::NAME_W-1:0]   module_tag_out,
    output logic [srtl_pkg::COUNT_W-1:0]  entry_count_out
);
    import srtl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WALK_RD,
        S_WALK_CMP,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       lo_reg, hi_reg;
    logic [CW-1:0]       idx_reg;
    logic [1:0]          cmd_reg;
    logic [ADDR_W-1:0]   key_reg;
    logic [ADDR_W-1:0]   size_in_reg;
    logic [NAME_W-1:0]   name_in_reg;
    logic [ADDR_W-1:0]   near_reg;
    logic                first_reg;
    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic [IDX_W-1:0]    eidx_reg;
    logic [NAME_W-1:0]   name_out_reg;
    logic [ADDR_W-1:0]   off_reg;
    logic [ADDR_W-1:0]   orig_reg;
    logic [NAME_W-1:0]   tag_reg;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    entry_t              ram_wdata, ram_rdata;
    logic [CW-1:0]       mid;
    logic [ADDR_W-1:0]   diff;
    logic [ADDR_W-1:0]   gap;

    srtl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // search midpoint, containment and early-stop arithmetic
    assign mid  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign diff = key_reg - ram_rdata.start;
    assign gap  = near_reg - ram_rdata.start;

    // RAM address and write control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_SRCH_RD:
            begin
                ram_raddr = mid[AW-1:0];
            end
            S_SHIFT_RD:
            begin
                ram_raddr = idx_reg[AW-1:0] - AW'(1);
            end
            S_SHIFT_WR:
            begin
                ram_we = 1'b1;
            end
            S_DONE:
            begin
                ram_we = (cmd_reg == CMD_APPEND) && (status_reg == ST_OK) && !out_valid_reg;
                ram_wdata.start = key_reg;
                ram_wdata.size  = size_in_reg;
                ram_wdata.name  = name_in_reg;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            idx_reg       <= '0;
            cmd_reg       <= CMD_NOP;
            first_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !out_valid_reg)
                    begin
                        cmd_reg      <= cmd;
                        size_in_reg  <= entry_size;
                        name_in_reg  <= name_handle;
                        status_reg   <= ST_OK;
                        eidx_reg     <= '0;
                        name_out_reg <= '0;
                        off_reg      <= '0;
                        orig_reg     <= '0;
                        tag_reg      <= '0;
                        lo_reg       <= '0;
                        hi_reg       <= count_reg;
                        case (cmd)
                            CMD_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            CMD_APPEND:
                            begin
                                key_reg <= entry_start;
                                if (count_reg == CW'(TABLE_DEPTH))
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_SRCH_RD;
                                end
                            end
                            CMD_LOOKUP:
                            begin
                                key_reg   <= target_address;
                                orig_reg  <= original_address;
                                tag_reg   <= module_tag;
                                state_reg <= S_SRCH_RD;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SRCH_RD:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        idx_reg   <= mid;
                        state_reg <= S_SRCH_CMP;
                    end
                    else if (cmd_reg == CMD_APPEND)
                    begin
                        // lo is the insert point; shift rows from the top down
                        idx_reg   <= count_reg;
                        state_reg <= (count_reg == lo_reg) ? S_DONE : S_SHIFT_RD;
                    end
                    else if (lo_reg == '0)
                    begin
                        status_reg <= ST_MISS;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= lo_reg - CW'(1);
                        first_reg <= 1'b1;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_SRCH_CMP:
                begin
                    if (key_reg >= ram_rdata.start)
                    begin
                        lo_reg <= idx_reg + CW'(1);
                    end
                    else
                    begin
                        hi_reg <= idx_reg;
                    end
                    state_reg <= S_SRCH_RD;
                end
                S_SHIFT_RD:
                begin
                    state_reg <= S_SHIFT_WR;
                end
                S_SHIFT_WR:
                begin
                    idx_reg   <= idx_reg - CW'(1);
                    state_reg <= (idx_reg - CW'(1) == lo_reg) ? S_DONE : S_SHIFT_RD;
                end
                S_WALK_RD:
                begin
                    state_reg <= S_WALK_CMP;
                end
                S_WALK_CMP:
                begin
                    first_reg <= 1'b0;
                    if (first_reg)
                    begin
                        near_reg <= ram_rdata.start;
                    end
                    if (key_reg < ram_rdata.start)
                    begin
                        status_reg <= ST_MISS;
                        state_reg  <= S_DONE;
                    end
                    else if (diff < ram_rdata.size)
                    begin
                        eidx_reg     <= IDX_W'(idx_reg);
                        name_out_reg <= ram_rdata.name;
                        off_reg      <= diff;
                        state_reg    <= S_DONE;
                    end
                    else if ((!first_reg && ram_rdata.size < gap) || idx_reg == '0)
                    begin
                        status_reg <= ST_MISS;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - CW'(1);
                        state_reg <= S_WALK_RD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        if (cmd_reg == CMD_APPEND && status_reg == ST_OK)
                        begin
                            idx_reg   <= lo_reg;
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                    else if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // the final append write lands at lo_reg through idx_reg
    assign in_ready             = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid            = out_valid_reg;
    assign status               = status_reg;
    assign entry_index          = eidx_reg;
    assign name_handle_out      = name_out_reg;
    assign offset               = off_reg;
    assign original_address_out = orig_reg;
    assign module_tag_out       = tag_reg;
    assign entry_count_out      = COUNT_W'(count_reg);

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");
    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg || state_reg == S_IDLE)
        else $error("search bounds crossed");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(status_reg))
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("ready while busy");
`endif

endmodule
